@@ src/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator: pool size,
// field widths, request and response structs, status and state codes.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int ADDR_W     = 32;
    localparam int BS_W       = 16;
    localparam int REM_W      = BS_W + IDX_W;
    localparam int PROD_W     = BS_W + IDX_W;
    localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 1'b1;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 16'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_NONE_USED = 2'd2,
        STAT_OUTSIDE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_FREE_CHECK,
        ST_FREE_DIV,
        ST_FREE_PUSH
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
        logic [CNT_W-1:0]  used_count;
    } rsp_t;

endpackage

@@ src/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Free-list stack allocator for a pool of equal-sized blocks, with a shared
// compare/subtract unit that divides a freed offset by the block size.
// ----------------------------------------------------------------------------
// Flow: an allocate goes IDLE, ALLOC and back to IDLE with the result; a free goes
// IDLE, FREE_CHECK, where it may be refused (none in use, outside the pool), then
// FREE_DIV (4 divide steps, one quotient bit per cycle) and FREE_PUSH.
// One request at a time: busy stays high until the result strobe, and the
// next start is taken in the cycle done is high. done lasts one cycle.
// Reset: stack holds 0..NUM_BLOCKS-1, nothing in use, base 0, block size 4.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 done,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [BS_W-1:0]     bsize_reg;
    logic [IDX_W-1:0]    stack_reg [NUM_BLOCKS];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    div_reg, div_next;
    logic [IDX_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic                stack_we;
    logic [IDX_W-1:0]    stack_waddr;
    logic [IDX_W-1:0]    stack_wdata;

    logic [ADDR_W-1:0]   offset;
    logic [ADDR_W-1:0]   limit;
    logic [PROD_W-1:0]   product;
    logic [IDX_W-1:0]    top_idx;
    logic [CNT_W-1:0]    count_dec;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign offset    = addr_reg - base_reg;
    assign limit     = ADDR_W'({bsize_reg, {IDX_W{1'b0}}});
    assign top_idx   = stack_reg[count_reg[IDX_W-1:0]];
    assign product   = PROD_W'(top_idx) * PROD_W'(bsize_reg);
    assign count_dec = count_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            base_reg  <= '0;
            bsize_reg <= BLOCK_SIZE_RESET;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                stack_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE_ADDRESS: base_reg  <= cfg_data;
                    REG_BLOCK_SIZE:   bsize_reg <= cfg_data[BS_W-1:0];
                    default:          ;
                endcase
            end
            if (stack_we)
            begin
                stack_reg[stack_waddr] <= stack_wdata;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        stack_we    = 1'b0;
        stack_waddr = count_dec[IDX_W-1:0];
        stack_wdata = quo_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req.kind;
                    addr_next  = req.address;
                    state_next = (req.kind == KIND_ALLOC) ? ST_ALLOC : ST_FREE_CHECK;
                end
            end

            ST_ALLOC:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (count_reg == CNT_W'(NUM_BLOCKS))
                begin
                    rsp_next.block_address = '0;
                    rsp_next.status        = STAT_EXHAUSTED;
                    rsp_next.used_count    = count_reg;
                end
                else
                begin
                    count_next             = count_reg + CNT_W'(1);
                    rsp_next.block_address = base_reg + ADDR_W'(product);
                    rsp_next.status        = STAT_OK;
                    rsp_next.used_count    = count_reg + CNT_W'(1);
                end
            end

            ST_FREE_CHECK:
            begin
                // Quotient fits IDX_W bits only when offset < size << IDX_W;
                // a zero size fails this test too.
                rsp_next.block_address = '0;
                rsp_next.used_count    = count_reg;
                if (count_reg == '0)
                begin
                    rsp_next.status = STAT_NONE_USED;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (offset >= limit)
                begin
                    rsp_next.status = STAT_OUTSIDE;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    rem_next   = offset[REM_W-1:0];
                    div_next   = REM_W'({bsize_reg, {(IDX_W-1){1'b0}}});
                    quo_next   = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = ST_FREE_DIV;
                end
            end

            ST_FREE_DIV:
            begin
                // One restoring step per cycle: compare, subtract, shift
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                    quo_next = {quo_reg[IDX_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[IDX_W-2:0], 1'b0};
                end
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_FREE_PUSH;
                end
            end

            ST_FREE_PUSH:
            begin
                done_next              = 1'b1;
                state_next             = ST_IDLE;
                rsp_next.block_address = '0;
                if (CNT_W'(quo_reg) >= CNT_W'(NUM_BLOCKS))
                begin
                    rsp_next.status     = STAT_OUTSIDE;
                    rsp_next.used_count = count_reg;
                end
                else
                begin
                    stack_we            = 1'b1;
                    count_next          = count_dec;
                    rsp_next.status     = STAT_OK;
                    rsp_next.used_count = count_dec;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ dv/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker
// Watches the request, response and register ports of the block pool
// allocator. Keeps its own free-list stack and pool registers, predicts the
// response of every accepted request and compares each strobed response,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module fbpa_checker
    import fbpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  req_t                 req,
    input  logic                 done,
    input  rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output int                   outstanding,
    output int                   mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ADDR_W-1:0] pool_base;
    logic [BS_W-1:0]   pool_bsize;
    logic [IDX_W-1:0]  free_idx [NUM_BLOCKS];
    logic [CNT_W-1:0]  blocks_used;

    rsp_t awaited_rsp [$];
    int   err_count = 0;

    assign mismatches = err_count;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic reset_pool();
        pool_base   = '0;
        pool_bsize  = BLOCK_SIZE_RESET;
        blocks_used = '0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            free_idx[i] = i[IDX_W-1:0];
        end
    endtask

    // Pop or push the free-list stack and return the response it produces.
    function automatic rsp_t serve_request(input req_t r);
        rsp_t              o;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] quot;
        o.block_address = '0;
        o.status        = STAT_OK;
        if (r.kind == KIND_ALLOC)
        begin
            if (blocks_used >= NUM_BLOCKS)
            begin
                o.status = STAT_EXHAUSTED;
            end
            else
            begin
                o.block_address = pool_base + ADDR_W'(free_idx[blocks_used])
                                  * ADDR_W'(pool_bsize);
                blocks_used++;
            end
        end
        else if (blocks_used == 0)
        begin
            o.status = STAT_NONE_USED;
        end
        else if (pool_bsize == 0)
        begin
            o.status = STAT_OUTSIDE;
        end
        else
        begin
            offset = r.address - pool_base;
            quot   = offset / ADDR_W'(pool_bsize);
            if (quot >= NUM_BLOCKS)
            begin
                o.status = STAT_OUTSIDE;
            end
            else
            begin
                blocks_used--;
                free_idx[blocks_used] = quot[IDX_W-1:0];
            end
        end
        o.used_count = blocks_used;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        if (!rst_n)
        begin
            reset_pool();
            awaited_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare first: a new request can be taken on the strobe cycle.
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    report($sformatf("response with nothing outstanding: addr %h st %0d cnt %0d",
                                     rsp.block_address, rsp.status, rsp.used_count));
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.block_address !== want.block_address)
                        report($sformatf("block_address %h, expected %h",
                                         rsp.block_address, want.block_address));
                    if (rsp.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         rsp.status, want.status));
                    if (rsp.used_count !== want.used_count)
                        report($sformatf("used_count %0d, expected %0d",
                                         rsp.used_count, want.used_count));
                end
            end
            if (start && !busy)
            begin
                awaited_rsp.push_back(serve_request(req));
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_BASE_ADDRESS)
                    pool_base = cfg_data;
                else if (cfg_index == REG_BLOCK_SIZE)
                    pool_bsize = cfg_data[BS_W-1:0];
            end
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

@@ dv/fixed_block_pool_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Drives allocate and free requests into the block pool allocator with
// random gaps, reprograms base and block size between phases, and takes the
// verdict from the checker that predicts and compares every response.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_t                 req;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    int                   outstanding;
    int                   mismatches;
    int                   cycle_count = 0;

    logic [ADDR_W-1:0]    cur_base;
    logic [BS_W-1:0]      cur_size;

    fixed_block_pool_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fbpa_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one request after a gap and hold it until the transfer.
    task automatic issue(input logic kind, input logic [ADDR_W-1:0] addr, input int gap);
        req_t r;
        r.kind    = kind;
        r.address = addr;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Drop start and hold until every predicted response has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy) @(posedge clk);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [BS_W-1:0] size);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BASE_ADDRESS;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_BLOCK_SIZE;
        cfg_data  <= ADDR_W'(size);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_base = base;
        cur_size = size;
    endtask

    function automatic logic [ADDR_W-1:0] pick_free_address();
        int                sel;
        int                off;
        logic [ADDR_W-1:0] a;
        sel = $urandom_range(0, 99);
        off = (cur_size == 0) ? 0 : $urandom_range(0, int'(cur_size) - 1);
        if (sel < 70)
            a = cur_base + ADDR_W'($urandom_range(0, NUM_BLOCKS - 1)) * ADDR_W'(cur_size)
                + ADDR_W'(off);
        else if (sel < 80)
            a = $urandom();
        else if (sel < 90)
            a = cur_base + ADDR_W'(NUM_BLOCKS) * ADDR_W'(cur_size)
                + ADDR_W'($urandom_range(0, 255));
        else
            a = cur_base - 1 - ADDR_W'($urandom_range(0, 255));
        return a;
    endfunction

    task automatic run_phase(input int count, input int alloc_pct, input int max_gap);
        int gap;
        for (int n = 0; n < count; n++)
        begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (n == count / 2)
                drain();
            if ($urandom_range(0, 99) < alloc_pct)
                issue(KIND_ALLOC, $urandom(), gap);
            else
                issue(KIND_FREE, pick_free_address(), gap);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_BASE_ADDRESS;
        cfg_data  <= '0;
        cur_base  = '0;
        cur_size  = BLOCK_SIZE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: free with nothing in use, two allocates, unaligned free, out of pool.
        issue(KIND_FREE, 32'h0000_0000, 1);
        issue(KIND_ALLOC, 32'hFFFF_FFFF, 0);
        issue(KIND_ALLOC, 32'h0000_0000, 2);
        issue(KIND_FREE, 32'h0000_0007, 0);
        issue(KIND_FREE, 32'h0000_0040, 3);
        issue(KIND_FREE, 32'hFFFF_FFFF, 0);

        // Largest block size near the top of memory: addresses wrap; exhaust.
        set_pool(32'hFFFF_FF00, 16'hFFFF);
        for (int i = 0; i < NUM_BLOCKS - 1; i++)
            issue(KIND_ALLOC, $urandom(), $urandom_range(0, 1));
        issue(KIND_ALLOC, 32'h0, 0);
        issue(KIND_FREE, 32'hFFFF_FE00, 0);
        issue(KIND_FREE, 32'hFFFF_FF00 + 32'd3 * 32'h0000_FFFF, 0);

        // Zero block size: allocate returns base, free is out of pool.
        set_pool(32'h0000_0000, 16'h0000);
        issue(KIND_ALLOC, 32'h0, 0);
        issue(KIND_FREE, 32'h0, 0);

        set_pool($urandom(), 16'($urandom_range(1, 64)));
        run_phase(90, 50, 4);
        set_pool(32'h0000_0000, 16'h0001);
        run_phase(90, 60, 0);
        set_pool(32'hFFFF_FFFF, 16'hFFFF);
        run_phase(90, 40, 4);
        set_pool($urandom(), 16'($urandom()));
        run_phase(90, 70, 4);
        set_pool($urandom(), 16'($urandom_range(1, 16)));
        run_phase(90, 30, 0);
        set_pool($urandom(), 16'($urandom_range(1, 4096)));
        run_phase(90, 50, 4);

        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/fbpa_pkg.sv
src/fixed_block_pool_allocator.sv
dv/fbpa_checker.sv
dv/fixed_block_pool_allocator_tb.sv
